/* rtl/srdiv_pkg.sv */
// Shared definitions for the signed restoring divider.
// Holds the result status codes; no dependencies.
package srdiv_pkg;

  // Fixed width of the operand and result ports.
  localparam int unsigned FIELD_BITS = 32;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DIV_ZERO = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

endpackage

/* rtl/signed_restoring_divider.sv */
// Signed restoring divider, one quotient bit per pipeline stage.
// Path from the accepting edge to the edge that takes the result:
// input register, WIDTH shift-subtract stages, output register.
// Throughput: one transaction per cycle; busy is always low and the receiver cannot stall.
// Reset (rst, synchronous) clears the stage valid bits and the done strobe only.
// Depends on srdiv_pkg.
module signed_restoring_divider #(
  parameter int WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [srdiv_pkg::FIELD_BITS-1:0] dividend,
  input  logic signed [srdiv_pkg::FIELD_BITS-1:0] divisor,
  output logic                                  done,
  output logic signed [srdiv_pkg::FIELD_BITS-1:0] quotient,
  output logic signed [srdiv_pkg::FIELD_BITS-1:0] remainder,
  output srdiv_pkg::status_t                    status
);

  import srdiv_pkg::*;

  typedef struct packed {
    logic [WIDTH-1:0] rem;    // partial remainder
    logic [WIDTH-1:0] aq;     // unused dividend bits above, quotient bits below
    logic [WIDTH-1:0] dvs;    // divisor magnitude
    logic             neg_q;
    logic             neg_r;
    logic             zero;
    logic             ovf;
  } stage_t;

  localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};

  stage_t           pipe [0:WIDTH];
  logic [WIDTH:0]   vld;

  logic signed [WIDTH-1:0] a_w;
  logic signed [WIDTH-1:0] b_w;
  logic [WIDTH-1:0]        mag_a;
  logic [WIDTH-1:0]        mag_b;

  assign busy = 1'b0;

  // Operands are sign-extended or truncated to the working width.
  always_comb begin
    a_w   = WIDTH'(dividend);
    b_w   = WIDTH'(divisor);
    mag_a = a_w[WIDTH-1] ? (~a_w + 1'b1) : a_w;
    mag_b = b_w[WIDTH-1] ? (~b_w + 1'b1) : b_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= start;
    end
    pipe[0].rem   <= '0;
    pipe[0].aq    <= mag_a;
    pipe[0].dvs   <= mag_b;
    pipe[0].neg_q <= a_w[WIDTH-1] ^ b_w[WIDTH-1];
    pipe[0].neg_r <= a_w[WIDTH-1];
    pipe[0].zero  <= (b_w == '0);
    pipe[0].ovf   <= (a_w == MOST_NEG) && (b_w == '1);
  end

  for (genvar g = 0; g < WIDTH; g++) begin : g_step
    logic [WIDTH-1:0] rem_sh;
    logic [WIDTH:0]   diff;
    logic             borrow;

    // For a nonzero divisor the partial remainder stays below the divisor magnitude, so the shift cannot overflow.
    always_comb begin
      rem_sh = {pipe[g].rem[WIDTH-2:0], pipe[g].aq[WIDTH-1]};
      diff   = {1'b0, rem_sh} - {1'b0, pipe[g].dvs};
      borrow = diff[WIDTH];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
      pipe[g+1].rem   <= borrow ? rem_sh : diff[WIDTH-1:0];
      pipe[g+1].aq    <= {pipe[g].aq[WIDTH-2:0], ~borrow};
      pipe[g+1].dvs   <= pipe[g].dvs;
      pipe[g+1].neg_q <= pipe[g].neg_q;
      pipe[g+1].neg_r <= pipe[g].neg_r;
      pipe[g+1].zero  <= pipe[g].zero;
      pipe[g+1].ovf   <= pipe[g].ovf;
    end
  end

  logic [WIDTH-1:0] q_fix;
  logic [WIDTH-1:0] r_fix;

  // Negating a zero remainder leaves it zero, so no separate test is needed.
  always_comb begin
    q_fix = pipe[WIDTH].neg_q ? (~pipe[WIDTH].aq + 1'b1) : pipe[WIDTH].aq;
    r_fix = pipe[WIDTH].neg_r ? (~pipe[WIDTH].rem + 1'b1) : pipe[WIDTH].rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[WIDTH];
    end
    if (pipe[WIDTH].zero) begin
      quotient  <= '0;
      remainder <= '0;
      status    <= STATUS_DIV_ZERO;
    end else begin
      quotient  <= FIELD_BITS'($signed(q_fix));
      remainder <= FIELD_BITS'($signed(r_fix));
      status    <= pipe[WIDTH].ovf ? STATUS_OVERFLOW : STATUS_OK;
    end
  end

  // Every accepted transaction produces its result strobe at the end of the pipeline.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(WIDTH+2) done)
    else $error("result strobe missing after pipeline latency");

  a_div_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_DIV_ZERO) |-> (quotient == '0 && remainder == '0))
    else $error("divide by zero result not cleared");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_OVERFLOW) |->
      (quotient == FIELD_BITS'($signed(MOST_NEG)) && remainder == '0))
    else $error("overflow result does not wrap to most negative value");

endmodule
